[hw/rtl/slebd_pkg.sv]
// shared types, constants and marker table for the signed leb128 section decoder
package slebd_pkg;

    localparam int MARKER_LEN  = 17;
    localparam int HDR_IDX_W   = 5;
    localparam int BYTE_W      = 8;
    localparam int VALUE_W     = 32;
    localparam int IDX_W       = 26;
    localparam int ACC_W       = 64;
    localparam int RAW_W       = 32;
    localparam int LEN_W       = 32;
    localparam int SHIFT_W     = 7;
    localparam int CFG_DATA_W  = 26;
    localparam int CFG_INDEX_W = 1;
    localparam int OUT_TDATA_W = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH_MODE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ELEM_COUNT = 1'b1;

    localparam logic [CFG_DATA_W-1:0] ELEM_COUNT_RESET = 26'd1024;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_SWALLOW,
        PH_RAW
    } t_phase;

    typedef struct packed {
        logic                  wide_mode;
        logic [CFG_DATA_W-1:0] elem_count;
    } t_cfg;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [IDX_W-1:0]   element_index;
        logic               last;
        logic               error;
    } t_result;

    // ascii marker text, one byte per header position
    function automatic logic [BYTE_W-1:0] marker_byte(input logic [HDR_IDX_W-1:0] pos);
        logic [BYTE_W-1:0] ch;
        case (pos)
            5'd0:    ch = 8'h43;
            5'd1:    ch = 8'h4F;
            5'd2:    ch = 8'h4D;
            5'd3:    ch = 8'h50;
            5'd4:    ch = 8'h52;
            5'd5:    ch = 8'h45;
            5'd6:    ch = 8'h53;
            5'd7:    ch = 8'h53;
            5'd8:    ch = 8'h45;
            5'd9:    ch = 8'h44;
            5'd10:   ch = 8'h5F;
            5'd11:   ch = 8'h4C;
            5'd12:   ch = 8'h45;
            5'd13:   ch = 8'h42;
            5'd14:   ch = 8'h31;
            5'd15:   ch = 8'h32;
            5'd16:   ch = 8'h38;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[hw/rtl/slebd_front.sv]
// front end: stream byte acceptance and byte queue toward the decoder
module slebd_front
    import slebd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_data,
    output logic              o_q_valid,
    output logic [BYTE_W-1:0] o_q_data,
    input  logic              i_q_pop
);

    logic [BYTE_W-1:0] r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_count;
    logic [QPTR_W-1:0] n_wp;
    logic [QPTR_W-1:0] n_rp;
    logic [QPTR_W:0]   n_count;
    logic              push;
    logic              pop;

    assign o_ready   = (r_count != (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_q_valid = (r_count != '0);
    assign o_q_data  = r_mem[r_rp];
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && o_q_valid;

    always_comb begin
        n_wp    = push ? r_wp + 1'b1 : r_wp;
        n_rp    = pop ? r_rp + 1'b1 : r_rp;
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

[hw/rtl/slebd_back.sv]
// back end: header match, raw assembly, leb128 decode and result register
module slebd_back
    import slebd_pkg::*;
#(
    parameter int COUNT_WIDTH = 26
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_q_valid,
    input  logic [BYTE_W-1:0] i_q_data,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_result           o_out
);

    localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(MARKER_LEN - 1);

    function automatic logic [VALUE_W-1:0] narrow(input logic wide, input logic [ACC_W-1:0] v);
        logic [VALUE_W-1:0] r;
        if (wide) begin
            r = v[VALUE_W-1:0];
        end else begin
            r = {{16{v[15]}}, v[15:0]};
        end
        return r;
    endfunction

    t_phase                 r_phase, n_phase;
    logic [BYTE_W-1:0]      r_hdr [MARKER_LEN];
    logic [HDR_IDX_W-1:0]   r_hc, n_hc;
    logic                   r_match, n_match;
    logic                   r_replay, n_replay;
    logic [HDR_IDX_W-1:0]   r_rp, n_rp;
    logic [LEN_W-1:0]       r_pl, n_pl;
    logic [LEN_W-1:0]       r_pc, n_pc;
    logic [ACC_W-1:0]       r_acc, n_acc;
    logic [SHIFT_W-1:0]     r_bs, n_bs;
    logic [COUNT_WIDTH-1:0] r_ed, n_ed;
    logic [RAW_W-1:0]       r_raw, n_raw;
    logic [1:0]             r_rbi, n_rbi;
    logic                   r_err_pend, n_err_pend;
    logic                   r_out_valid;
    t_result                r_out;

    logic                   do_restart;
    t_phase                 rst_phase;
    logic                   emit;
    t_result                res;

    logic                   out_free;
    logic                   have_work;
    logic                   fire;
    logic                   byte_fire;
    logic [BYTE_W-1:0]      b;
    logic [COUNT_WIDTH-1:0] cnt;
    logic [COUNT_WIDTH-1:0] eff_cnt;
    logic [COUNT_WIDTH:0]   ed_inc;
    logic                   is_last;
    logic [COUNT_WIDTH-1:0] ed_next;
    logic [ACC_W-1:0]       acc_mask;
    logic [SHIFT_W-1:0]     acc_bits;
    logic [ACC_W-1:0]       acc_or;
    logic [ACC_W-1:0]       acc_val;
    logic [SHIFT_W-1:0]     bs_nx;
    logic [LEN_W-1:0]       pc_nx;
    logic                   pay_end;
    logic [LEN_W-1:0]       pl_nx;
    logic [RAW_W-1:0]       raw_nx;
    logic [2:0]             raw_bytes;
    logic                   raw_done;
    logic                   hdr_match;
    logic [HDR_IDX_W-1:0]   hc_nx;
    logic                   hdr_full;
    logic                   hdr_we;

    assign out_free  = !r_out_valid || i_out_ready;
    assign have_work = r_err_pend || r_replay || i_q_valid;
    assign fire      = have_work && out_free;
    assign byte_fire = fire && !r_err_pend;
    assign o_q_pop   = fire && !r_err_pend && !r_replay;
    assign b         = r_replay ? r_hdr[r_rp] : i_q_data;

    assign cnt     = COUNT_WIDTH'(i_cfg.elem_count);
    assign eff_cnt = (cnt == '0) ? {{(COUNT_WIDTH-1){1'b0}}, 1'b1} : cnt;
    assign ed_inc  = {1'b0, r_ed} + 1'b1;
    assign is_last = ed_inc >= {1'b0, eff_cnt};
    assign ed_next = ed_inc[COUNT_WIDTH-1:0];

    // leb128 accumulate with sign fill
    assign acc_mask = i_cfg.wide_mode ? {ACC_W{1'b1}} : {{(ACC_W-32){1'b0}}, {32{1'b1}}};
    assign acc_bits = i_cfg.wide_mode ? SHIFT_W'(64) : SHIFT_W'(32);
    assign bs_nx    = (r_bs < SHIFT_W'(64)) ? r_bs + SHIFT_W'(7) : r_bs;
    assign acc_or   = (r_bs < acc_bits)
                    ? (r_acc | ((ACC_W'(b[6:0]) << r_bs) & acc_mask)) : r_acc;
    assign acc_val  = (bs_nx < acc_bits && b[6])
                    ? (acc_or | (({ACC_W{1'b1}} << bs_nx) & acc_mask)) : acc_or;
    assign pc_nx    = r_pc + 1'b1;
    assign pay_end  = pc_nx >= r_pl;

    assign pl_nx     = r_pl | (LEN_W'(b) << {r_rbi, 3'b000});
    assign raw_nx    = r_raw | (RAW_W'(b) << {r_rbi, 3'b000});
    assign raw_bytes = i_cfg.wide_mode ? 3'd4 : 3'd2;
    assign raw_done  = ({1'b0, r_rbi} + 3'd1) >= raw_bytes;

    assign hdr_match = ((r_hc == '0) || r_match) && (b == marker_byte(r_hc));
    assign hc_nx     = r_hc + 1'b1;
    assign hdr_full  = (hc_nx == HDR_IDX_W'(MARKER_LEN));
    assign hdr_we    = byte_fire && (r_phase == PH_HEADER);

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_hc       = r_hc;
        n_match    = r_match;
        n_replay   = r_replay;
        n_rp       = r_rp;
        n_pl       = r_pl;
        n_pc       = r_pc;
        n_acc      = r_acc;
        n_bs       = r_bs;
        n_ed       = r_ed;
        n_raw      = r_raw;
        n_rbi      = r_rbi;
        n_err_pend = r_err_pend;
        do_restart = 1'b0;
        rst_phase  = PH_HEADER;

        if (fire && r_err_pend) begin
            n_err_pend = 1'b0;
            do_restart = 1'b1;
        end else if (byte_fire) begin
            if (r_replay) begin
                n_rp = r_rp + 1'b1;
                if (r_rp == HDR_LAST) begin
                    n_replay = 1'b0;
                end
            end
            case (r_phase)
                PH_HEADER: begin
                    n_hc    = hc_nx;
                    n_match = hdr_match;
                    if (hdr_full) begin
                        do_restart = 1'b1;
                        if (hdr_match) begin
                            rst_phase = PH_LENGTH;
                        end else begin
                            rst_phase = PH_RAW;
                            n_replay  = 1'b1;
                            n_rp      = '0;
                        end
                    end
                end
                PH_LENGTH: begin
                    n_pl = pl_nx;
                    if (r_rbi == 2'd3) begin
                        n_rbi   = '0;
                        n_phase = PH_PAYLOAD;
                        n_pc    = '0;
                        n_acc   = '0;
                        n_bs    = '0;
                        n_ed    = '0;
                        if (pl_nx == '0) begin
                            do_restart = 1'b1;
                        end
                    end else begin
                        n_rbi = r_rbi + 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    n_pc = pc_nx;
                    if (!b[7]) begin
                        n_acc = '0;
                        n_bs  = '0;
                        n_ed  = ed_next;
                        if (is_last) begin
                            if (pay_end) begin
                                do_restart = 1'b1;
                            end else begin
                                n_phase = PH_SWALLOW;
                            end
                        end else if (pay_end) begin
                            n_err_pend = 1'b1;
                        end
                    end else begin
                        n_acc = acc_or;
                        n_bs  = bs_nx;
                        if (pay_end) begin
                            do_restart = 1'b1;
                        end
                    end
                end
                PH_SWALLOW: begin
                    n_pc = pc_nx;
                    if (pay_end) begin
                        do_restart = 1'b1;
                    end
                end
                PH_RAW: begin
                    if (raw_done) begin
                        n_rbi = '0;
                        n_raw = '0;
                        n_ed  = ed_next;
                        if (is_last) begin
                            do_restart = 1'b1;
                        end
                    end else begin
                        n_rbi = r_rbi + 1'b1;
                        n_raw = raw_nx;
                    end
                end
                default: begin
                    do_restart = 1'b1;
                end
            endcase
        end

        if (do_restart) begin
            n_phase = rst_phase;
            n_hc    = '0;
            n_pl    = '0;
            n_pc    = '0;
            n_acc   = '0;
            n_bs    = '0;
            n_ed    = '0;
            n_raw   = '0;
            n_rbi   = '0;
        end
    end

    // result of this step
    always_comb begin
        emit              = 1'b0;
        res.value         = '0;
        res.element_index = IDX_W'(r_ed);
        res.last          = 1'b1;
        res.error         = 1'b1;
        if (fire && r_err_pend) begin
            emit = 1'b1;
        end else if (byte_fire) begin
            case (r_phase)
                PH_LENGTH: begin
                    if (r_rbi == 2'd3 && pl_nx == '0) begin
                        emit              = 1'b1;
                        res.element_index = '0;
                    end
                end
                PH_PAYLOAD: begin
                    if (!b[7]) begin
                        emit      = 1'b1;
                        res.value = narrow(i_cfg.wide_mode, acc_val);
                        res.last  = is_last;
                        res.error = 1'b0;
                    end else if (pay_end) begin
                        emit = 1'b1;
                    end
                end
                PH_RAW: begin
                    if (raw_done) begin
                        emit      = 1'b1;
                        res.value = narrow(i_cfg.wide_mode, ACC_W'(raw_nx));
                        res.last  = is_last;
                        res.error = 1'b0;
                    end
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hc        <= '0;
            r_match     <= 1'b0;
            r_replay    <= 1'b0;
            r_rp        <= '0;
            r_pl        <= '0;
            r_pc        <= '0;
            r_acc       <= '0;
            r_bs        <= '0;
            r_ed        <= '0;
            r_raw       <= '0;
            r_rbi       <= '0;
            r_err_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_hc       <= n_hc;
            r_match    <= n_match;
            r_replay   <= n_replay;
            r_rp       <= n_rp;
            r_pl       <= n_pl;
            r_pc       <= n_pc;
            r_acc      <= n_acc;
            r_bs       <= n_bs;
            r_ed       <= n_ed;
            r_raw      <= n_raw;
            r_rbi      <= n_rbi;
            r_err_pend <= n_err_pend;
            if (fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (hdr_we) begin
            r_hdr[r_hc] <= b;
        end
        if (fire && emit) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[hw/rtl/sleb128_section_decoder.sv]
// top level of the signed leb128 section decoder: config registers, front and back
// a byte is queued in the front end; its completed result is registered in the back end
// throughput: 1 byte per cycle while the result register is free; a raw header replays its
// 17 buffered bytes, and a payload ending just after a non-final element needs an error step
// synchronous active-low reset clears control state, mode 16-bit, element count 1024
module sleb128_section_decoder
    import slebd_pkg::*;
#(
    parameter int COUNT_WIDTH = 26
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [BYTE_W-1:0]      s_axis_tdata,  // stream_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // value, element_index, zero pad
    output logic                   m_axis_tlast,
    output logic                   m_axis_tuser   // error
);

    t_cfg              r_cfg;
    logic              q_valid;
    logic [BYTE_W-1:0] q_data;
    logic              q_pop;
    logic              res_valid;
    t_result           res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wide_mode  <= 1'b0;
            r_cfg.elem_count <= ELEM_COUNT_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_WIDTH_MODE: r_cfg.wide_mode  <= i_cfg_data[0];
                CFG_ELEM_COUNT: r_cfg.elem_count <= i_cfg_data;
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    slebd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_data    (s_axis_tdata),
        .o_q_valid (q_valid),
        .o_q_data  (q_data),
        .i_q_pop   (q_pop)
    );

    slebd_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_q_pop     (q_pop),
        .o_out_valid (res_valid),
        .i_out_ready (m_axis_tready),
        .o_out       (res)
    );

    assign m_axis_tvalid = res_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - VALUE_W - IDX_W){1'b0}}, res.element_index, res.value};
    assign m_axis_tlast  = res.last;
    assign m_axis_tuser  = res.error;

endmodule

[hw/rtl/slebd_checker.sv]
// port-level assertion checker for the section decoder and its bind
module slebd_checker
    import slebd_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast,
    input logic                   m_axis_tuser
);

    // error result always closes the section
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("error result without tlast");

    // error result carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[VALUE_W-1:0] == '0)
        else $error("error result with nonzero value");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind sleb128_section_decoder slebd_checker u_checker (.*);

[bench/sleb128_section_decoder_tb.sv]
// self-checking bench for the signed leb128 section decoder with its scoreboard class
import slebd_pkg::*;

class leb_section_tracker;
    bit                    wide;
    logic [CFG_DATA_W-1:0] count;
    t_phase                phase;
    logic [7:0]            hdr [MARKER_LEN];
    int unsigned           hdr_cnt;
    logic [31:0]           pay_len;
    logic [31:0]           pay_used;
    logic [63:0]           acc;
    int unsigned           shift;
    logic [IDX_W-1:0]      done;
    logic [31:0]           raw_word;
    int unsigned           raw_pos;
    t_result               pending_elems[$];
    int unsigned           errors;

    function new();
        wide   = 1'b0;
        count  = ELEM_COUNT_RESET;
        errors = 0;
        restart();
    endfunction

    function void restart();
        phase    = PH_HEADER;
        hdr_cnt  = 0;
        pay_len  = '0;
        pay_used = '0;
        acc      = '0;
        shift    = 0;
        done     = '0;
        raw_word = '0;
        raw_pos  = 0;
    endfunction

    function void write_reg(input logic [CFG_INDEX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_WIDTH_MODE) begin
            wide = data[0];
        end else begin
            count = data;
        end
    endfunction

    function void push(input logic [31:0] value, input logic [IDX_W-1:0] idx,
                       input bit last, input bit err);
        t_result r;
        r.value         = value;
        r.element_index = idx;
        r.last          = last;
        r.error         = err;
        pending_elems.push_back(r);
    endfunction

    // returns 1 on the final element of the section
    function bit emit(input logic [63:0] v);
        logic [CFG_DATA_W-1:0] eff;
        logic [31:0]           value;
        bit                    last;
        eff   = (count == '0) ? CFG_DATA_W'(1) : count;
        value = wide ? v[31:0] : {{16{v[15]}}, v[15:0]};
        last  = ({1'b0, done} + 27'd1) >= {1'b0, eff};
        push(value, done, last, 1'b0);
        done = done + 1'b1;
        return last;
    endfunction

    function bit raw_byte(input logic [7:0] b);
        int unsigned bytes;
        logic [31:0] w;
        bytes = wide ? 4 : 2;
        raw_word |= {24'b0, b} << (8 * raw_pos);
        raw_pos++;
        if (raw_pos < bytes) begin
            return 1'b0;
        end
        raw_pos  = 0;
        w        = raw_word;
        raw_word = '0;
        if (emit({32'b0, w})) begin
            restart();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function void decode_byte(input logic [7:0] b);
        logic [7:0]  held [MARKER_LEN];
        bit          match;
        int unsigned acc_bits;
        logic [63:0] mask;
        logic [63:0] v;
        case (phase)
            PH_HEADER: begin
                if (hdr_cnt < MARKER_LEN) hdr[hdr_cnt] = b;
                hdr_cnt++;
                if (hdr_cnt >= MARKER_LEN) begin
                    match = 1'b1;
                    for (int i = 0; i < MARKER_LEN; i++) begin
                        if (hdr[i] != marker_byte(HDR_IDX_W'(i))) match = 1'b0;
                    end
                    if (match) begin
                        restart();
                        phase = PH_LENGTH;
                    end else begin
                        held = hdr;
                        restart();
                        phase = PH_RAW;
                        // header bytes past the final element start the next header
                        for (int i = 0; i < MARKER_LEN; i++) begin
                            if (raw_byte(held[i])) begin
                                for (int j = 0; j < MARKER_LEN - 1 - i; j++) begin
                                    hdr[j] = held[i + 1 + j];
                                end
                                hdr_cnt = MARKER_LEN - 1 - i;
                                break;
                            end
                        end
                    end
                end
            end
            PH_LENGTH: begin
                pay_len |= {24'b0, b} << (8 * raw_pos);
                if (raw_pos == 3) begin
                    raw_pos  = 0;
                    phase    = PH_PAYLOAD;
                    pay_used = '0;
                    acc      = '0;
                    shift    = 0;
                    done     = '0;
                    if (pay_len == '0) begin
                        push('0, done, 1'b1, 1'b1);
                        restart();
                    end
                end else begin
                    raw_pos++;
                end
            end
            PH_PAYLOAD: begin
                acc_bits = wide ? 64 : 32;
                mask     = wide ? {64{1'b1}} : 64'hFFFF_FFFF;
                pay_used++;
                if (shift < acc_bits) acc |= ({57'b0, b[6:0]} << shift) & mask;
                if (shift < 64) shift += 7;
                if (!b[7]) begin
                    if (shift < acc_bits && b[6]) acc |= ({64{1'b1}} << shift) & mask;
                    v     = acc;
                    acc   = '0;
                    shift = 0;
                    if (emit(v)) begin
                        if (pay_used >= pay_len) begin
                            restart();
                        end else begin
                            phase = PH_SWALLOW;
                        end
                        return;
                    end
                end
                if (pay_used >= pay_len) begin
                    push('0, done, 1'b1, 1'b1);
                    restart();
                end
            end
            PH_SWALLOW: begin
                pay_used++;
                if (pay_used >= pay_len) restart();
            end
            PH_RAW: begin
                void'(raw_byte(b));
            end
            default: begin
                restart();
            end
        endcase
    endfunction

    task report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task check_elem(input t_result got);
        t_result want;
        if (pending_elems.size() == 0) begin
            report($sformatf("unexpected result value %h idx %0d last %0b err %0b",
                             got.value, got.element_index, got.last, got.error));
        end else begin
            want = pending_elems.pop_front();
            if (got !== want) begin
                report($sformatf("got value %h idx %0d last %0b err %0b, want %h %0d %0b %0b",
                                 got.value, got.element_index, got.last, got.error,
                                 want.value, want.element_index, want.last, want.error));
            end
        end
    endtask

    task flag_leftover();
        if (pending_elems.size() != 0) begin
            report($sformatf("%0d results never arrived", pending_elems.size()));
        end
    endtask
endclass

module sleb128_section_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned RANDOM_BYTES = 8;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [BYTE_W-1:0]      s_axis_tdata;   // stream_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // value, element_index, zero pad
    logic                   m_axis_tlast;   // last
    logic                   m_axis_tuser;   // error

    leb_section_tracker sb = new();
    bit                 steady;
    int unsigned        bytes_sent;
    int unsigned        cycle_count;
    int unsigned        stall_left;

    sleb128_section_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else if (steady || $urandom_range(0, 9) < 7) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= 1'b0;
            stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.value         = m_axis_tdata[VALUE_W-1:0];
            got.element_index = m_axis_tdata[VALUE_W +: IDX_W];
            got.last          = m_axis_tlast;
            got.error         = m_axis_tuser;
            sb.check_elem(got);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = (steady || $urandom_range(0, 9) < 6) ? 0 : pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.decode_byte(b);
        bytes_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_elems.size() != 0) @(posedge i_clk);
    endtask

    task automatic configure(input bit mode, input logic [CFG_DATA_W-1:0] cnt);
        drain_results();
        repeat (8) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_WIDTH_MODE;
        i_cfg_data  <= CFG_DATA_W'(mode);
        @(posedge i_clk);
        sb.write_reg(CFG_WIDTH_MODE, CFG_DATA_W'(mode));
        i_cfg_index <= CFG_ELEM_COUNT;
        i_cfg_data  <= cnt;
        @(posedge i_clk);
        sb.write_reg(CFG_ELEM_COUNT, cnt);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic void leb_encode(input longint v, ref logic [7:0] q[$]);
        logic [7:0] b;
        bit         more;
        more = 1'b1;
        while (more) begin
            b = {1'b0, v[6:0]};
            v = v >>> 7;
            if ((v == 0 && !b[6]) || (v == -1 && b[6])) begin
                more = 1'b0;
            end else begin
                b[7] = 1'b1;
            end
            q.push_back(b);
        end
    endfunction

    // arbitrary continuation run, possibly longer than the accumulator
    function automatic void add_run(input int unsigned len, ref logic [7:0] q[$]);
        for (int i = 0; i + 1 < len; i++) q.push_back({1'b1, 7'($urandom)});
        q.push_back({1'b0, 7'($urandom)});
    endfunction

    function automatic longint rand_value();
        case ($urandom_range(0, 3))
            0:       return longint'($urandom_range(0, 140)) - 70;
            1:       return longint'(shortint'($urandom));
            2:       return longint'(int'($urandom));
            default: return longint'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_count();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r < 8) return CFG_DATA_W'($urandom_range(1, 8));
        return CFG_DATA_W'($urandom_range(9, 12));
    endfunction

    task automatic finish_raw();
        while (sb.phase == PH_RAW) send_byte(8'($urandom));
    endtask

    task automatic run_header(input bit broken);
        int unsigned first;
        int unsigned flip;
        logic [7:0]  b;
        first = sb.hdr_cnt;
        flip  = $urandom_range(first, MARKER_LEN - 1);
        for (int i = first; i < MARKER_LEN; i++) begin
            b = marker_byte(HDR_IDX_W'(i));
            if (broken && i == flip) b ^= 8'h01 << $urandom_range(0, 7);
            send_byte(b);
        end
    endtask

    task automatic run_section(input logic [7:0] pl[$], input bit broken);
        logic [31:0] len;
        len = 32'(pl.size());
        run_header(broken);
        if (sb.phase == PH_LENGTH) begin
            for (int k = 0; k < 4; k++) send_byte(len[8*k +: 8]);
            foreach (pl[i]) send_byte(pl[i]);
        end else begin
            finish_raw();
        end
    endtask

    task automatic run_raw(input logic [7:0] hdr[$]);
        for (int i = sb.hdr_cnt; i < MARKER_LEN; i++) send_byte(hdr[i]);
        finish_raw();
    endtask

    task automatic random_section();
        logic [7:0]  pl[$];
        int unsigned r;
        int unsigned eff;
        int unsigned nvals;
        r     = $urandom_range(0, 99);
        eff   = (sb.count == '0) ? 1 : sb.count;
        nvals = $urandom_range(0, (eff > 12) ? 14 : eff + 2);
        if (r < 70) begin
            for (int i = 0; i < nvals; i++) begin
                if ($urandom_range(0, 4) == 0) begin
                    add_run($urandom_range(1, 12), pl);
                end else begin
                    leb_encode(rand_value(), pl);
                end
            end
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 3)) pl.push_back(8'($urandom));
            end
            run_section(pl, r >= 60);
        end else if (r < 90) begin
            repeat (MARKER_LEN) pl.push_back(8'($urandom));
            run_raw(pl);
        end else begin
            repeat ($urandom_range(1, 20)) send_byte(8'($urandom));
            finish_raw();
        end
    endtask

    initial begin
        logic [7:0]  pl[$];
        int unsigned start;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_index   <= CFG_WIDTH_MODE;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, payload runs out
        pl = {};
        leb_encode(1, pl);
        leb_encode(-2, pl);
        leb_encode(300, pl);
        run_section(pl, 1'b0);

        // 16-bit extremes and an overlong run
        configure(1'b0, 5);
        pl = {};
        leb_encode(0, pl);
        leb_encode(-1, pl);
        leb_encode(32767, pl);
        leb_encode(-32768, pl);
        repeat (11) pl.push_back(8'hFF);
        pl.push_back(8'h7F);
        run_section(pl, 1'b0);

        // 32-bit extremes, runs ending past and just below 64 bits, swallowed tail
        configure(1'b1, 4);
        pl = {};
        leb_encode(2147483647, pl);
        leb_encode(-2147483648, pl);
        repeat (10) pl.push_back(8'h80);
        pl.push_back(8'h40);
        repeat (8) pl.push_back(8'h80);
        pl.push_back(8'h40);
        pl.push_back(8'hAA);
        pl.push_back(8'h55);
        run_section(pl, 1'b0);

        // empty payload
        pl = {};
        run_section(pl, 1'b0);

        // largest count, last byte completes an element and exhausts the payload
        configure(1'b1, {CFG_DATA_W{1'b1}});
        pl = {};
        leb_encode(-5, pl);
        leb_encode(64, pl);
        run_section(pl, 1'b0);

        // zero count acts as one
        configure(1'b0, 0);
        pl = {};
        leb_encode(100, pl);
        leb_encode(-100, pl);
        pl.push_back(8'h00);
        run_section(pl, 1'b0);

        // raw header giving eight elements at once
        configure(1'b0, 9);
        pl = {8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'h01,
              8'h00, 8'h34, 8'h12, 8'hCD, 8'hAB, 8'h55, 8'hAA, 8'h80};
        run_raw(pl);

        // raw section shorter than the header, leftover bytes carried over
        configure(1'b0, 2);
        pl = {8'hFF, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00,
              8'h00, 8'h00, 8'h80, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A};
        run_raw(pl);
        configure(1'b1, 5);
        pl = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
              8'h00, 8'h00, 8'h00, 8'h00, 8'hFE, 8'hDC, 8'hBA, 8'h98};
        run_raw(pl);

        configure(1'b1, 1);
        pl = {};
        leb_encode(-123456789, pl);
        run_section(pl, 1'b0);

        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) begin
            if ($urandom_range(0, 9) < 4) configure(1'($urandom), rand_count());
            steady = ($urandom_range(0, 4) == 0);
            random_section();
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        sb.flag_leftover();
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
